[rtl/depq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// depq_pkg
// Shared constants and codes of the double-ended priority queue.
// ----------------------------------------------------------------------------
package depq_pkg;

    localparam int unsigned DataW     = 32;
    localparam int unsigned CountW    = 7;
    localparam int unsigned ReqW      = 2;
    localparam int unsigned StatW     = 2;
    localparam int unsigned CAPACITY  = 64;

    localparam logic [ReqW-1:0] REQ_INSERT  = 2'd0;
    localparam logic [ReqW-1:0] REQ_DEL_MAX = 2'd1;
    localparam logic [ReqW-1:0] REQ_DEL_MIN = 2'd2;

    localparam logic [StatW-1:0] ST_DONE  = 2'd0;
    localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
    localparam logic [StatW-1:0] ST_FULL  = 2'd2;

endpackage
`default_nettype wire

[rtl/double_ended_priority_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Bounded multiset of signed values with insert, remove-max and remove-min.
// ----------------------------------------------------------------------------
// Values sit in ascending order in one memory, addressed as a circular buffer
// (base pointer plus count), so removing the minimum or maximum only moves a
// pointer. A removal then reads the new extreme from memory before the block
// is ready for the next request. A removal that empties the set, an ignored
// removal, a dropped insert or an unused code skips the memory. An insert
// shifts the entries above the new value up by one, one read-modify-write
// per entry through the single memory port, so it lasts longer the more
// held values are larger than the new one. The output word is held in a
// register. A request is accepted once the word of the previous one sits in
// that register, and a word not yet taken holds the next one back until it
// is delivered. Current min and max live in registers.
// ----------------------------------------------------------------------------
module double_ended_priority_queue #(
    parameter int unsigned CAPACITY = depq_pkg::CAPACITY
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [depq_pkg::ReqW-1:0]         i_req_type,
    input  wire logic signed [depq_pkg::DataW-1:0] i_insert_value,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [depq_pkg::DataW-1:0]      o_max_value,
    output logic signed [depq_pkg::DataW-1:0]      o_min_value,
    output logic [depq_pkg::CountW-1:0]            o_entry_count,
    output logic [depq_pkg::StatW-1:0]             o_status
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CapC = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SCAN_WAIT, S_FIX_RD, S_FIX_WAIT, S_OUT
    } t_state;

    t_state r_state;
    logic [AW-1:0] r_base;      // physical address of the minimum
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_pos;       // logical index being compared during insert
    logic signed [depq_pkg::DataW-1:0] r_val, r_min, r_max;
    logic [depq_pkg::StatW-1:0] r_stat;
    logic [depq_pkg::ReqW-1:0] r_req;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [depq_pkg::DataW-1:0] wdata, rdata;

    depq_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // logical to physical address, wrapping at capacity
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [CW-1:0] i);
        logic [CW:0] s;
        s = (CW+1)'(b) + (CW+1)'(i);
        if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
        return s[AW-1:0];
    endfunction

    logic signed [depq_pkg::DataW-1:0] rd_s;
    assign rd_s = $signed(rdata);

    // memory port control
    always_comb begin
        we = 1'b0;
        waddr = phys(r_base, r_pos);
        wdata = rdata;
        raddr = phys(r_base, r_pos - CW'(1));
        case (r_state)
            S_SCAN_WAIT: begin
                // shift entry pos-1 up to pos, or drop the new value at pos
                we = 1'b1;
                if (r_pos != '0 && rd_s > r_val) wdata = rdata;
                else wdata = r_val;
            end
            S_FIX_RD: begin
                // read the new extreme after a removal
                if (r_req == depq_pkg::REQ_DEL_MAX) raddr = phys(r_base, r_count - CW'(1));
                else raddr = r_base;
            end
            default: ;
        endcase
    end

    // control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= '0;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req  <= i_req_type;
                        r_val  <= i_insert_value;
                        if (i_req_type == depq_pkg::REQ_INSERT) begin
                            if (r_count == CapC) begin
                                r_stat <= depq_pkg::ST_FULL;
                                r_state <= S_OUT;
                            end else if (r_count == '0) begin
                                r_stat <= depq_pkg::ST_DONE;
                                r_pos <= '0;
                                r_state <= S_SCAN_WAIT;
                                r_min <= i_insert_value;
                                r_max <= i_insert_value;
                            end else begin
                                r_stat <= depq_pkg::ST_DONE;
                                r_pos <= r_count;
                                r_state <= S_SCAN;
                                if (i_insert_value < r_min) r_min <= i_insert_value;
                                if (i_insert_value > r_max) r_max <= i_insert_value;
                            end
                        end else if (i_req_type == depq_pkg::REQ_DEL_MAX ||
                                     i_req_type == depq_pkg::REQ_DEL_MIN) begin
                            if (r_count == '0) begin
                                r_stat <= depq_pkg::ST_EMPTY;
                                r_state <= S_OUT;
                            end else begin
                                r_stat <= depq_pkg::ST_DONE;
                                r_count <= r_count - CW'(1);
                                if (i_req_type == depq_pkg::REQ_DEL_MIN)
                                    r_base <= phys(r_base, CW'(1));
                                r_state <= (r_count != CW'(1)) ? S_FIX_RD : S_OUT;
                            end
                        end else begin
                            r_stat <= depq_pkg::ST_DONE;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SCAN: r_state <= S_SCAN_WAIT;
                S_SCAN_WAIT: begin
                    if (r_pos != '0 && rd_s > r_val) begin
                        // after shifting entry 0 the value goes to the bottom next cycle
                        r_pos <= r_pos - CW'(1);
                        r_state <= (r_pos == CW'(1)) ? S_SCAN_WAIT : S_SCAN;
                    end else begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_OUT;
                    end
                end
                S_FIX_RD: r_state <= S_FIX_WAIT;
                S_FIX_WAIT: begin
                    if (r_req == depq_pkg::REQ_DEL_MAX) r_max <= rd_s;
                    else r_min <= rd_s;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        o_max_value <= (r_count == '0) ? '0 : r_max;
                        o_min_value <= (r_count == '0) ? '0 : r_min;
                        o_entry_count <= depq_pkg::CountW'(r_count);
                        o_status <= r_stat;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_valid && i_ready && r_state != S_OUT) o_valid <= 1'b0;
        end
    end

    assign o_ready = (r_state == S_IDLE) && i_rst_n;

endmodule
`default_nettype wire

[rtl/depq_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// depq_ram
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module depq_ram #(
    parameter int unsigned DEPTH = depq_pkg::CAPACITY,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [AW-1:0]              i_waddr,
    input  wire logic [depq_pkg::DataW-1:0] i_wdata,
    input  wire logic [AW-1:0]              i_raddr,
    output logic      [depq_pkg::DataW-1:0] o_rdata
);

    logic [depq_pkg::DataW-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// double_ended_priority_queue testbench
// Drives insert / remove-max / remove-min requests through the valid-ready
// input, predicts max, min, count and status with a sorted-array model, and
// compares every output word in order. Runs several idle/stall phases.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [depq_pkg::DataW-1:0] max_v;
        logic signed [depq_pkg::DataW-1:0] min_v;
        logic [depq_pkg::CountW-1:0]       cnt;
        logic [depq_pkg::StatW-1:0]        stat;
    } t_depq_word;

    localparam logic [depq_pkg::ReqW-1:0] REQ_UNUSED = 2'd3;
    localparam int WatchLimit = 20000;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_ready;
    logic [depq_pkg::ReqW-1:0]         i_req_type = depq_pkg::REQ_INSERT;
    logic signed [depq_pkg::DataW-1:0] i_insert_value = '0;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic signed [depq_pkg::DataW-1:0] o_max_value;
    logic signed [depq_pkg::DataW-1:0] o_min_value;
    logic [depq_pkg::CountW-1:0]       o_entry_count;
    logic [depq_pkg::StatW-1:0]        o_status;

    // predicted set, ascending
    logic signed [depq_pkg::DataW-1:0] held_vals[$];
    t_depq_word                        expected_words[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int words_checked = 0;
    int items_sent = 0;
    int full_hits = 0;
    int empty_hits = 0;
    int quiet_cycles = 0;

    double_ended_priority_queue uut (.*);

    always #6 i_clk = ~i_clk;

    // update the set and work out the word for one request
    function automatic t_depq_word predict_word(logic [depq_pkg::ReqW-1:0] req,
                                                logic signed [depq_pkg::DataW-1:0] v);
        t_depq_word w;
        int pos;
        w.stat = depq_pkg::ST_DONE;
        if (req == depq_pkg::REQ_INSERT) begin
            if (held_vals.size() >= depq_pkg::CAPACITY) begin
                w.stat = depq_pkg::ST_FULL;
            end else begin
                pos = held_vals.size();
                while (pos > 0 && held_vals[pos-1] > v) pos--;
                held_vals.insert(pos, v);
            end
        end else if (req == depq_pkg::REQ_DEL_MAX || req == depq_pkg::REQ_DEL_MIN) begin
            if (held_vals.size() == 0) w.stat = depq_pkg::ST_EMPTY;
            else if (req == depq_pkg::REQ_DEL_MAX) void'(held_vals.pop_back());
            else void'(held_vals.pop_front());
        end
        if (held_vals.size() == 0) begin
            w.max_v = '0;
            w.min_v = '0;
        end else begin
            w.max_v = held_vals[$];
            w.min_v = held_vals[0];
        end
        w.cnt = depq_pkg::CountW'(held_vals.size());
        if (w.stat == depq_pkg::ST_FULL) full_hits++;
        if (w.stat == depq_pkg::ST_EMPTY) empty_hits++;
        return w;
    endfunction

    // send one word, predicting at acceptance
    task automatic send_req(logic [depq_pkg::ReqW-1:0] req,
                            logic signed [depq_pkg::DataW-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_insert_value <= v;
        do @(posedge i_clk); while (!o_ready);
        expected_words.insert(expected_words.size(), predict_word(req, v));
        items_sent++;
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic signed [depq_pkg::DataW-1:0] rand_value();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(8))) - 4;
            default: return $signed($urandom());
        endcase
    endfunction

    // receiver stalls
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // output checker
    always @(posedge i_clk) begin
        t_depq_word exp_w;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: max %0d min %0d cnt %0d st %0d",
                    o_max_value, o_min_value, o_entry_count, o_status);
            end else begin
                exp_w = expected_words.pop_front();
                words_checked++;
                if (exp_w.max_v !== o_max_value || exp_w.min_v !== o_min_value ||
                    exp_w.cnt !== o_entry_count || exp_w.stat !== o_status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp max %0d min %0d cnt %0d st %0d, ",
                                  "got %0d %0d %0d %0d"},
                            exp_w.max_v, exp_w.min_v, exp_w.cnt, exp_w.stat,
                            o_max_value, o_min_value, o_entry_count, o_status);
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit) begin
            $display("FAIL double_ended_priority_queue");
            $finish;
        end
    end

    // empty removals, extremes, duplicates, unused code
    task automatic test_directed;
        send_req(depq_pkg::REQ_DEL_MAX, 0);
        send_req(depq_pkg::REQ_DEL_MIN, 0);
        send_req(REQ_UNUSED, 32'sh7fffffff);
        send_req(depq_pkg::REQ_INSERT, 32'sh7fffffff);
        send_req(depq_pkg::REQ_INSERT, 32'sh80000000);
        send_req(depq_pkg::REQ_INSERT, 0);
        send_req(depq_pkg::REQ_INSERT, 0);
        send_req(depq_pkg::REQ_INSERT, -1);
        send_req(depq_pkg::REQ_DEL_MAX, 32'sh5555aaaa);
        send_req(depq_pkg::REQ_DEL_MIN, -1);
        send_req(depq_pkg::REQ_DEL_MIN, 0);
        send_req(depq_pkg::REQ_DEL_MAX, 0);
        send_req(depq_pkg::REQ_DEL_MIN, 0);
        send_req(depq_pkg::REQ_DEL_MIN, 0);
        drain();
    endtask

    task automatic test_fill_full;
        while (held_vals.size() < depq_pkg::CAPACITY)
            send_req(depq_pkg::REQ_INSERT, rand_value());
        send_req(depq_pkg::REQ_INSERT, 32'sh7fffffff);
        send_req(depq_pkg::REQ_INSERT, 32'sh80000000);
        while (held_vals.size() > 0)
            send_req($urandom_range(1) ? depq_pkg::REQ_DEL_MAX : depq_pkg::REQ_DEL_MIN,
                     rand_value());
        send_req(depq_pkg::REQ_DEL_MIN, 0);
        drain();
    endtask

    // random mix, leaning to inserts or removals by phase
    task automatic test_random(int n, int ins_pct);
        logic [depq_pkg::ReqW-1:0] req;
        repeat (n) begin
            if ($urandom_range(99) < 2) req = REQ_UNUSED;
            else if ($urandom_range(99) < ins_pct) req = depq_pkg::REQ_INSERT;
            else req = $urandom_range(1) ? depq_pkg::REQ_DEL_MAX : depq_pkg::REQ_DEL_MIN;
            send_req(req, rand_value());
        end
        drain();
    endtask

    task automatic run_phase(int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        test_random(150, 70);
        test_random(150, 35);
        test_random(60, 55);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_full();
        run_phase(0, 0);
        run_phase(59, 0);
        run_phase(0, 59);
        run_phase(33, 33);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_fill_full();
        $display("sent %0d requests, checked %0d words", items_sent, words_checked);
        $display("full drops %0d, empty removals %0d", full_hits, empty_hits);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("PASS double_ended_priority_queue");
        end else begin
            $display("FAIL double_ended_priority_queue");
        end
        $finish;
    end

endmodule
